// ===== design/c8_pkg.sv =====
// Shared constants, types and the font table of the CHIP-8 core.
package c8_pkg;

    localparam int C8_MEM_BYTES   = 4096;
    localparam int C8_MEM_AW      = $clog2(C8_MEM_BYTES);
    localparam int C8_FB_BYTES    = 256;
    localparam int C8_FB_AW       = $clog2(C8_FB_BYTES);
    localparam int C8_STACK_DEPTH = 16;
    localparam int C8_FONT_BYTES  = 80;
    localparam logic [11:0] C8_PC_START = 12'h200;

    // Command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // Register ALU sub codes (low nibble of 8XYN)
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;

    // Key and misc sub codes (low byte)
    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;
    localparam logic [7:0] MISC_GDT = 8'h07;
    localparam logic [7:0] MISC_SDT = 8'h15;
    localparam logic [7:0] MISC_SST = 8'h18;
    localparam logic [7:0] MISC_ADI = 8'h1E;
    localparam logic [7:0] MISC_FNT = 8'h29;
    localparam logic [7:0] MISC_BCD = 8'h33;
    localparam logic [7:0] MISC_STR = 8'h55;
    localparam logic [7:0] MISC_LDR = 8'h65;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_RD_WAIT, ST_F0, ST_F1, ST_F2, ST_VX, ST_VY,
        ST_EXEC, ST_CLR, ST_D0, ST_D1, ST_D2, ST_D3, ST_BSUB, ST_BWR,
        ST_ST, ST_LD0, ST_LD1, ST_ADV, ST_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        sub;
    } t_alu_req;

    localparam logic [7:0] C8_FONT [0:C8_FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Initial memory content: font glyphs at the bottom, zero elsewhere
    function automatic logic [7:0] font_byte(input logic [C8_MEM_AW-1:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a < C8_MEM_AW'(C8_FONT_BYTES)) begin
            v = C8_FONT[a[6:0]];
        end
        return v;
    endfunction

endpackage

// ===== design/c8_if.sv =====
// Command and result channel interfaces of the CHIP-8 core.
interface c8_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys_pressed;
    logic [7:0]  random_byte;
    modport source (output valid, command, address, data, keys_pressed, random_byte,
                    input ready);
    modport sink (input valid, command, address, data, keys_pressed, random_byte,
                  output ready);
endinterface

interface c8_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic        display_changed;
    logic        sound_on;
    logic [7:0]  read_data;
    logic        unknown_opcode;
    modport source (output valid, program_counter, executed_opcode, display_changed,
                    sound_on, read_data, unknown_opcode, input ready);
    modport sink (input valid, program_counter, executed_opcode, display_changed,
                  sound_on, read_data, unknown_opcode, output ready);
endinterface

// ===== design/chip8_interpreter_core.sv =====
// Load writes memory and reports; read fetches a framebuffer byte; execute fetches the
// opcode, reads VX and VY, executes, then steps through sprite rows, the screen clear,
// BCD subtract steps and digit writes, or registers stored or loaded, before advancing PC.
// One item at a time; the sequencer and the single shared adder set the rate.
// Reset: synchronous, active low; an init pass fills memory with the font and
// zeros and clears the framebuffer before the first item is taken.
module chip8_interpreter_core #(
    parameter int STACK_DEPTH = c8_pkg::C8_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    c8_cmd_if.sink    i_cmd,
    c8_res_if.source  o_res
);
    import c8_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH);

    t_state r_state, n_state;

    logic [C8_MEM_AW-1:0] r_cnt;
    logic [11:0]          r_pc;
    logic [15:0]          r_i;
    logic [SPW-1:0]       r_sp;
    logic [7:0]           r_dt, r_st;
    logic [7:0]           r_v [16];
    logic [11:0]          r_stk [STACK_DEPTH];

    logic [1:0]  r_cmd;
    logic [15:0] r_op;
    logic [7:0]  r_vx, r_vy, r_rnd, r_rdat, r_spr, r_fb, r_tmp;
    logic [15:0] r_keys;
    logic [2:0]  r_adv;
    logic        r_bad, r_drew, r_sound, r_flag;
    logic [3:0]  r_row, r_dig;
    logic [1:0]  r_ph;

    logic        r_res_valid;
    logic [11:0] r_res_pc;
    logic [15:0] r_res_op;
    logic        r_res_drew, r_res_sound, r_res_bad;
    logic [7:0]  r_res_rdat;

    t_alu_req             alu_req;
    logic [16:0]          alu_res;
    logic                 alu_zero;
    logic                 mem_we, fb_we;
    logic [C8_MEM_AW-1:0] mem_addr;
    logic [7:0]           mem_wd, mem_rd;
    logic [C8_FB_AW-1:0]  fb_addr;
    logic [7:0]           fb_wd, fb_rd;

    logic        accept;
    logic [3:0]  op_grp, op_x, op_y, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [4:0]  py;
    logic [15:0] win;
    logic        key_down, last_row, flag_d;
    logic [SPW-1:0] sp_dec, sp_inc;

    c8_alu u_alu (.i_req(alu_req), .o_res(alu_res));

    c8_ram #(.WIDTH(8), .DEPTH(C8_MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr), .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

    c8_ram #(.WIDTH(8), .DEPTH(C8_FB_BYTES)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_addr(fb_addr), .i_wdata(fb_wd), .o_rdata(fb_rd)
    );

    // Decode fields and helpers
    assign op_grp   = r_op[15:12];
    assign op_x     = r_op[11:8];
    assign op_y     = r_op[7:4];
    assign op_n     = r_op[3:0];
    assign op_nn    = r_op[7:0];
    assign op_nnn   = r_op[11:0];
    assign alu_zero = (alu_res[15:0] == 16'd0);
    assign key_down = r_keys[r_vx[3:0]];
    assign py       = r_vy[4:0] + {1'b0, r_row};
    assign win      = {r_spr, 8'h00} >> r_vx[2:0];
    assign last_row = ((r_row + 4'd1) == op_n);
    assign flag_d   = r_flag | (|(r_fb & win[7:0]));
    assign sp_dec   = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - SPW'(1);
    assign sp_inc   = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + SPW'(1);

    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_res_valid || o_res.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:    if (r_cnt == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.command == CMD_EXEC) begin
                        n_state = ST_F0;
                    end else if (i_cmd.command == CMD_READ) begin
                        n_state = ST_RD_WAIT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD_WAIT: n_state = ST_DONE;
            ST_F0:      n_state = ST_F1;
            ST_F1:      n_state = ST_F2;
            ST_F2:      n_state = ST_VX;
            ST_VX:      n_state = ST_VY;
            ST_VY:      n_state = ST_EXEC;
            ST_EXEC: begin
                n_state = ST_ADV;
                if (r_op == OP_CLS) begin
                    n_state = ST_CLR;
                end else if (op_grp == OP_DRW && op_n != 4'd0) begin
                    n_state = ST_D0;
                end else if (op_grp == OP_MISC && op_nn == MISC_BCD) begin
                    n_state = ST_BSUB;
                end else if (op_grp == OP_MISC && op_nn == MISC_STR) begin
                    n_state = ST_ST;
                end else if (op_grp == OP_MISC && op_nn == MISC_LDR) begin
                    n_state = ST_LD0;
                end
            end
            ST_CLR:     if (r_cnt[C8_FB_AW-1:0] == '1) n_state = ST_ADV;
            ST_D0:      n_state = ST_D1;
            ST_D1:      n_state = ST_D2;
            ST_D2:      n_state = ST_D3;
            ST_D3:      n_state = last_row ? ST_ADV : ST_D0;
            ST_BSUB:    if (r_ph == 2'd2 || alu_res[16]) n_state = ST_BWR;
            ST_BWR:     n_state = (r_ph == 2'd2) ? ST_ADV : ST_BSUB;
            ST_ST:      if (r_row == op_x) n_state = ST_ADV;
            ST_LD0:     n_state = ST_LD1;
            ST_LD1:     n_state = (r_row == op_x) ? ST_ADV : ST_LD0;
            ST_ADV:     n_state = ST_DONE;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Drive the adder and both memories
    always_comb begin
        alu_req  = '0;
        mem_we   = 1'b0;
        mem_addr = r_pc;
        mem_wd   = 8'h00;
        fb_we    = 1'b0;
        fb_addr  = {py, r_vx[5:3]};
        fb_wd    = 8'h00;
        unique case (r_state)
            ST_INIT: begin
                mem_we   = 1'b1;
                mem_addr = r_cnt;
                mem_wd   = font_byte(r_cnt);
                fb_we    = (r_cnt[C8_MEM_AW-1:C8_FB_AW] == '0);
                fb_addr  = r_cnt[C8_FB_AW-1:0];
            end
            ST_IDLE: begin
                mem_we   = accept && (i_cmd.command == CMD_LOAD);
                mem_addr = i_cmd.address;
                mem_wd   = i_cmd.data;
                fb_addr  = i_cmd.address[C8_FB_AW-1:0];
            end
            ST_F1: mem_addr = r_pc + 12'd1;
            ST_EXEC: begin
                alu_req.a = {8'h00, r_vx};
                unique case (op_grp)
                    OP_SE, OP_SNE: begin
                        alu_req.b   = {8'h00, op_nn};
                        alu_req.sub = 1'b1;
                    end
                    OP_SEV: begin
                        alu_req.b   = {8'h00, r_vy};
                        alu_req.sub = 1'b1;
                    end
                    OP_ADD: alu_req.b = {8'h00, op_nn};
                    OP_ALU: begin
                        alu_req.b   = {8'h00, r_vy};
                        alu_req.sub = (op_n == ALU_SUB);
                    end
                    OP_MISC: begin
                        alu_req.a = r_i;
                        alu_req.b = {8'h00, r_vx};
                    end
                    default: alu_req.b = 16'd0;
                endcase
            end
            ST_CLR: begin
                fb_we   = 1'b1;
                fb_addr = r_cnt[C8_FB_AW-1:0];
            end
            ST_D0: begin
                alu_req.a = r_i;
                alu_req.b = {12'd0, r_row};
                mem_addr  = alu_res[11:0];
            end
            ST_D1: fb_addr = {py, r_vx[5:3] + 3'd1};
            ST_D2: begin
                fb_we = 1'b1;
                fb_wd = r_fb ^ win[15:8];
            end
            ST_D3: begin
                fb_addr = {py, r_vx[5:3] + 3'd1};
                fb_we   = 1'b1;
                fb_wd   = r_fb ^ win[7:0];
            end
            ST_BSUB: begin
                alu_req.a   = {8'h00, r_tmp};
                alu_req.b   = (r_ph == 2'd0) ? 16'd100 : 16'd10;
                alu_req.sub = 1'b1;
            end
            ST_BWR: begin
                alu_req.a = r_i;
                alu_req.b = {14'd0, r_ph};
                mem_we    = 1'b1;
                mem_addr  = alu_res[11:0];
                mem_wd    = (r_ph == 2'd2) ? r_tmp : {4'd0, r_dig};
            end
            ST_ST, ST_LD0: begin
                alu_req.a = r_i;
                alu_req.b = {12'd0, r_row};
                mem_we    = (r_state == ST_ST);
                mem_addr  = alu_res[11:0];
                mem_wd    = r_v[r_row];
            end
            ST_ADV: begin
                alu_req.a = {4'd0, r_pc};
                alu_req.b = {13'd0, r_adv};
            end
            default: alu_req = '0;
        endcase
    end

    // Architectural state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_pc        <= C8_PC_START;
            r_i         <= 16'd0;
            r_sp        <= '0;
            r_dt        <= 8'd0;
            r_st        <= 8'd0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stk[k] <= 12'd0;
        end else begin
            r_state <= n_state;
            if (o_res.valid && o_res.ready) r_res_valid <= 1'b0;
            unique case (r_state)
                ST_INIT, ST_CLR: r_cnt <= r_cnt + C8_MEM_AW'(1);
                ST_EXEC: begin
                    r_cnt <= '0;
                    unique case (op_grp)
                        OP_SYS: begin
                            if (r_op == OP_RET) begin
                                r_sp <= sp_dec;
                                r_pc <= r_stk[sp_dec];
                            end
                        end
                        OP_JP: r_pc <= op_nnn;
                        OP_CALL: begin
                            r_stk[r_sp] <= r_pc;
                            r_sp        <= sp_inc;
                            r_pc        <= op_nnn;
                        end
                        OP_LD:  r_v[op_x] <= op_nn;
                        OP_ADD: r_v[op_x] <= alu_res[7:0];
                        OP_ALU: begin
                            unique case (op_n)
                                ALU_MOV: r_v[op_x] <= r_vy;
                                ALU_OR: begin
                                    r_v[op_x] <= r_vx | r_vy;
                                    r_v[15]   <= 8'd0;
                                end
                                ALU_AND: begin
                                    r_v[op_x] <= r_vx & r_vy;
                                    r_v[15]   <= 8'd0;
                                end
                                ALU_XOR: begin
                                    r_v[op_x] <= r_vx ^ r_vy;
                                    r_v[15]   <= 8'd0;
                                end
                                ALU_ADD: begin
                                    r_v[op_x] <= alu_res[7:0];
                                    r_v[15]   <= {7'd0, alu_res[8]};
                                end
                                ALU_SUB: begin
                                    r_v[op_x] <= alu_res[7:0];
                                    r_v[15]   <= {7'd0, ~alu_res[16]};
                                end
                                default: r_v[15] <= r_v[15];
                            endcase
                        end
                        OP_LDI: r_i <= {4'd0, op_nnn};
                        OP_RND: r_v[op_x] <= r_rnd & op_nn;
                        OP_DRW: if (op_n == 4'd0) r_v[15] <= 8'd0;
                        OP_MISC: begin
                            unique case (op_nn)
                                MISC_GDT: r_v[op_x] <= r_dt;
                                MISC_SDT: r_dt <= r_vx;
                                MISC_SST: r_st <= r_vx;
                                MISC_ADI: begin
                                    r_i     <= alu_res[15:0];
                                    r_v[15] <= {7'd0, |alu_res[16:12]};
                                end
                                MISC_FNT: r_i <= 16'({r_vx[3:0], 2'b00}) + 16'(r_vx[3:0]);
                                default:  r_i <= r_i;
                            endcase
                        end
                        default: r_pc <= r_pc;
                    endcase
                end
                ST_D3:  if (last_row) r_v[15] <= {7'd0, flag_d};
                ST_LD1: r_v[r_row] <= mem_rd;
                ST_ADV: r_pc <= alu_res[11:0];
                ST_DONE: begin
                    r_res_valid <= 1'b1;
                    if (r_cmd == CMD_EXEC) begin
                        if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                        if (r_st != 8'd0) r_st <= r_st - 8'd1;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_cmd   <= i_cmd.command;
                    r_keys  <= i_cmd.keys_pressed;
                    r_rnd   <= i_cmd.random_byte;
                    r_sound <= (r_st != 8'd0);
                    r_rdat  <= 8'd0;
                    r_drew  <= 1'b0;
                    r_bad   <= 1'b0;
                    r_op    <= 16'd0;
                end
            end
            ST_RD_WAIT: r_rdat <= fb_rd;
            ST_F1: r_op[15:8] <= mem_rd;
            ST_F2: r_op[7:0]  <= mem_rd;
            ST_VX: r_vx <= r_v[op_x];
            ST_VY: r_vy <= r_v[op_y];
            ST_EXEC: begin
                r_row  <= 4'd0;
                r_flag <= 1'b0;
                r_tmp  <= r_vx;
                r_dig  <= 4'd0;
                r_ph   <= 2'd0;
                r_adv  <= 3'd2;
                r_bad  <= 1'b0;
                r_drew <= (r_op == OP_CLS) || (op_grp == OP_DRW);
                unique case (op_grp)
                    OP_SYS: begin
                        if (r_op != OP_CLS && r_op != OP_RET) begin
                            r_adv <= 3'd0;
                            r_bad <= 1'b1;
                        end
                    end
                    OP_JP, OP_CALL: r_adv <= 3'd0;
                    OP_SE, OP_SEV:  r_adv <= alu_zero ? 3'd4 : 3'd2;
                    OP_SNE:         r_adv <= alu_zero ? 3'd2 : 3'd4;
                    OP_LD, OP_ADD, OP_LDI, OP_RND, OP_DRW: r_adv <= 3'd2;
                    OP_ALU: begin
                        if (op_n > ALU_SUB) begin
                            r_adv <= 3'd0;
                            r_bad <= 1'b1;
                        end
                    end
                    OP_KEY: begin
                        if (op_nn == KEY_DOWN) begin
                            r_adv <= key_down ? 3'd4 : 3'd2;
                        end else if (op_nn == KEY_UP) begin
                            r_adv <= key_down ? 3'd2 : 3'd4;
                        end else begin
                            r_adv <= 3'd0;
                            r_bad <= 1'b1;
                        end
                    end
                    OP_MISC: begin
                        if (op_nn != MISC_GDT && op_nn != MISC_SDT && op_nn != MISC_SST &&
                            op_nn != MISC_ADI && op_nn != MISC_FNT && op_nn != MISC_BCD &&
                            op_nn != MISC_STR && op_nn != MISC_LDR) begin
                            r_adv <= 3'd0;
                            r_bad <= 1'b1;
                        end
                    end
                    default: begin
                        r_adv <= 3'd0;
                        r_bad <= 1'b1;
                    end
                endcase
            end
            ST_D1: begin
                r_spr <= mem_rd;
                r_fb  <= fb_rd;
            end
            ST_D2: begin
                r_fb   <= fb_rd;
                r_flag <= r_flag | (|(r_fb & win[15:8]));
            end
            ST_D3: begin
                r_flag <= flag_d;
                r_row  <= r_row + 4'd1;
            end
            ST_BSUB: begin
                if (r_ph != 2'd2 && !alu_res[16]) begin
                    r_tmp <= alu_res[7:0];
                    r_dig <= r_dig + 4'd1;
                end
            end
            ST_BWR: begin
                r_ph  <= r_ph + 2'd1;
                r_dig <= 4'd0;
            end
            ST_ST, ST_LD1: r_row <= r_row + 4'd1;
            ST_DONE: begin
                r_res_pc    <= r_pc;
                r_res_op    <= r_op;
                r_res_drew  <= r_drew;
                r_res_sound <= r_sound;
                r_res_rdat  <= r_rdat;
                r_res_bad   <= r_bad;
            end
            default: r_row <= r_row;
        endcase
    end

    // Result channel
    assign o_res.valid           = r_res_valid;
    assign o_res.program_counter = r_res_pc;
    assign o_res.executed_opcode = r_res_op;
    assign o_res.display_changed = r_res_drew;
    assign o_res.sound_on        = r_res_sound;
    assign o_res.read_data       = r_res_rdat;
    assign o_res.unknown_opcode  = r_res_bad;
endmodule

// ===== design/c8_ram.sv =====
// Generic single-port RAM with registered read.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/c8_alu.sv =====
// Shared add/subtract unit of the CHIP-8 core.
module c8_alu (
    input  c8_pkg::t_alu_req i_req,
    output logic [16:0]      o_res
);
    import c8_pkg::*;

    // Add or subtract; bit 16 is carry out or borrow
    always_comb begin
        if (i_req.sub) begin
            o_res = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            o_res = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end
endmodule
